>>> hw/rtl/abcr_pkg.sv
// Shared types, constants and helpers for the alternating-bit command responder.
package abcr_pkg;

   localparam int unsigned PEER_SLOTS_DEF   = 4;
   localparam int unsigned MAX_DATAGRAM_DEF = 128;

   localparam logic [31:0] PING_XOR      = 32'h413A0D53;
   localparam logic [7:0]  HDR_A_MASK    = 8'b1000_0000;
   localparam logic [7:0]  HDR_ACK_MASK  = 8'b0100_0000;
   localparam logic [7:0]  HDR_CMD_MASK  = 8'b0000_1111;

   // Reply lengths (bytes after the signature byte)
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_ACK  = 3'd1;
   localparam logic [2:0] LEN_ERR  = 3'd2;
   localparam logic [2:0] LEN_ECHO = 3'd5;

   // Register port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_FRAME_SIGNATURE       = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PING_OPCODE           = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_OPCODE          = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RESPONSE_CODE         = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ERROR_CODE            = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_BAD_LENGTH_ERROR      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_UNKNOWN_COMMAND_ERROR = 3'd6;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   typedef struct packed {
      logic [7:0] frame_signature;
      logic [3:0] ping_opcode;
      logic [3:0] color_opcode;
      logic [6:0] response_code;
      logic [6:0] error_code;
      logic [7:0] bad_length_error;
      logic [7:0] unknown_command_error;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_signature:       8'd0,
      ping_opcode:           4'd0,
      color_opcode:          4'd1,
      response_code:         7'd0,
      error_code:            7'd1,
      bad_length_error:      8'd0,
      unknown_command_error: 8'd1
   };

   // Classified datagram, as queued for the back end
   typedef struct packed {
      logic        ignore;
      logic [31:0] sender_id;
      logic [15:0] sender_port;
      logic        abit;
      logic        ack;
      logic        cmd_ping;
      logic        cmd_color;
      logic        ping_len_ok;
      logic        color_len_ok;
      logic [31:0] payload_bytes;
      logic [31:0] now_ms;
   } item_type;

   // One connection table entry
   typedef struct packed {
      logic [31:0] id;
      logic        toggle;
      logic [31:0] age;
      logic [39:0] reply;
      logic [2:0]  reply_length;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      id: 32'd0, toggle: 1'b1, age: 32'd0, reply: 40'd0, reply_length: LEN_NONE
   };

   function automatic logic [7:0] header_of(input logic [6:0] code, input logic abit);
      return {abit, code};
   endfunction

endpackage

>>> hw/rtl/abcr_if.sv
// Request and response channel interfaces of the command responder.
interface abcr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sender_id;
   logic [15:0] sender_port;
   logic [15:0] datagram_length;
   logic [7:0]  signature_byte;
   logic [7:0]  header_byte;
   logic [31:0] payload_bytes;
   logic [31:0] now_ms;

   modport source (
      output valid, sender_id, sender_port, datagram_length, signature_byte,
             header_byte, payload_bytes, now_ms,
      input  ready
   );
   modport sink (
      input  valid, sender_id, sender_port, datagram_length, signature_byte,
             header_byte, payload_bytes, now_ms,
      output ready
   );
endinterface

interface abcr_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_reply;
   logic [31:0] dest_id;
   logic [15:0] dest_port;
   logic [2:0]  reply_length;
   logic [39:0] reply_bytes;

   modport source (
      output valid, send_reply, dest_id, dest_port, reply_length, reply_bytes,
      input  ready
   );
   modport sink (
      input  valid, send_reply, dest_id, dest_port, reply_length, reply_bytes,
      output ready
   );
endinterface

>>> hw/rtl/abcr_csr.sv
// APB-style configuration registers of the command responder.
module abcr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [abcr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [abcr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [abcr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output abcr_pkg::cfg_type                 cfg
);

   abcr_pkg::cfg_type                    cfg_ff, cfg_in;
   logic [abcr_pkg::REG_IDX_W-1:0]       reg_idx;
   logic                                 wr_en;

   assign reg_idx    = csr_paddr[abcr_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            abcr_pkg::REG_FRAME_SIGNATURE:       cfg_in.frame_signature = csr_pwdata[7:0];
            abcr_pkg::REG_PING_OPCODE:           cfg_in.ping_opcode = csr_pwdata[3:0];
            abcr_pkg::REG_COLOR_OPCODE:          cfg_in.color_opcode = csr_pwdata[3:0];
            abcr_pkg::REG_RESPONSE_CODE:         cfg_in.response_code = csr_pwdata[6:0];
            abcr_pkg::REG_ERROR_CODE:            cfg_in.error_code = csr_pwdata[6:0];
            abcr_pkg::REG_BAD_LENGTH_ERROR:      cfg_in.bad_length_error = csr_pwdata[7:0];
            abcr_pkg::REG_UNKNOWN_COMMAND_ERROR: cfg_in.unknown_command_error = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         abcr_pkg::REG_FRAME_SIGNATURE:       csr_prdata = {24'd0, cfg_ff.frame_signature};
         abcr_pkg::REG_PING_OPCODE:           csr_prdata = {28'd0, cfg_ff.ping_opcode};
         abcr_pkg::REG_COLOR_OPCODE:          csr_prdata = {28'd0, cfg_ff.color_opcode};
         abcr_pkg::REG_RESPONSE_CODE:         csr_prdata = {25'd0, cfg_ff.response_code};
         abcr_pkg::REG_ERROR_CODE:            csr_prdata = {25'd0, cfg_ff.error_code};
         abcr_pkg::REG_BAD_LENGTH_ERROR:      csr_prdata = {24'd0, cfg_ff.bad_length_error};
         abcr_pkg::REG_UNKNOWN_COMMAND_ERROR: csr_prdata = {24'd0, cfg_ff.unknown_command_error};
         default:                             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= abcr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/abcr_front.sv
// Front end: takes request transfers and classifies each datagram.
module abcr_front #(
   parameter int unsigned MAX_DATAGRAM = abcr_pkg::MAX_DATAGRAM_DEF
) (
   abcr_req_if.sink              req_chan,
   input  abcr_pkg::cfg_type     cfg,
   input  logic                  q_full,
   output logic                  q_push,
   output abcr_pkg::item_type    q_push_item
);

   logic [15:0] dlen;
   logic [3:0]  cmd;
   logic        is_ping;

   assign dlen    = req_chan.datagram_length;
   assign cmd     = 4'(req_chan.header_byte & abcr_pkg::HDR_CMD_MASK);
   assign is_ping = (cmd == cfg.ping_opcode);

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid & !q_full;

   always_comb begin
      q_push_item.ignore        = (req_chan.sender_id == 32'd0) || (dlen == 16'd0)
                                  || (dlen > 16'(MAX_DATAGRAM))
                                  || (req_chan.signature_byte != cfg.frame_signature)
                                  || (dlen == 16'd1);
      q_push_item.sender_id     = req_chan.sender_id;
      q_push_item.sender_port   = req_chan.sender_port;
      q_push_item.abit          = |(req_chan.header_byte & abcr_pkg::HDR_A_MASK);
      q_push_item.ack           = |(req_chan.header_byte & abcr_pkg::HDR_ACK_MASK);
      // ping takes precedence when both opcodes are equal
      q_push_item.cmd_ping      = is_ping;
      q_push_item.cmd_color     = !is_ping && (cmd == cfg.color_opcode);
      q_push_item.ping_len_ok   = (dlen == 16'd6);
      // payload of 1, 3 or 4 bytes
      q_push_item.color_len_ok  = (dlen == 16'd3) || (dlen == 16'd5) || (dlen == 16'd6);
      q_push_item.payload_bytes = req_chan.payload_bytes;
      q_push_item.now_ms        = req_chan.now_ms;
   end

endmodule

>>> hw/rtl/abcr_queue.sv
// Short FIFO between front and back end.
module abcr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  abcr_pkg::item_type    push_item,
   output logic                  full,
   output logic                  q_valid,
   output abcr_pkg::item_type    q_item,
   input  logic                  pop
);

   abcr_pkg::item_type                     store_ff [abcr_pkg::QUEUE_DEPTH];
   logic [abcr_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [abcr_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [abcr_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                                   do_push, do_pop;

   assign full    = (count_ff == abcr_pkg::QUEUE_CNT_W'(abcr_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = store_ff[rd_ptr_ff];
   assign do_push = push & !full;
   assign do_pop  = pop & q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/abcr_back.sv
// Back end: connection table scan, reply build and response register.
module abcr_back #(
   parameter int unsigned PEER_SLOTS = abcr_pkg::PEER_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  abcr_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  abcr_pkg::item_type    q_item,
   output logic                  q_pop,
   abcr_rsp_if.source            rsp_chan
);

   localparam int unsigned SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PEER_SLOTS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_BUILD = 3'd4;

   abcr_pkg::entry_type   peer_mem [PEER_SLOTS];
   logic [PEER_SLOTS-1:0] valid_ff, valid_in;

   logic [2:0]            state_ff, state_in;
   logic [SLOT_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic                  eval_ff, eval_in;
   logic [SLOT_W-1:0]     rd_idx_ff;
   abcr_pkg::entry_type   rd_data_ff;
   logic                  hit_ff, hit_in;
   logic [SLOT_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [SLOT_W-1:0]     victim_ff, victim_in;
   logic [31:0]           best_age_ff, best_age_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  send_ff, send_in;
   logic [31:0]           dest_id_ff, dest_id_in;
   logic [15:0]           dest_port_ff, dest_port_in;
   logic [2:0]            rlen_ff, rlen_in;
   logic [39:0]           rbytes_ff, rbytes_in;

   abcr_pkg::entry_type   rd_entry, cur, new_entry;
   logic [SLOT_W-1:0]     slot, rd_addr;
   logic                  out_free, ign_done, commit, match, better;
   logic                  isnew, built, send;
   logic [39:0]           rep;
   logic [2:0]            rep_len;
   logic [7:0]            hdr_ok, hdr_err;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign slot     = hit_ff ? hit_idx_ff : victim_ff;
   assign rd_addr  = (state_ff == ST_SCAN) ? scan_cnt_ff : slot;
   assign rd_entry = valid_ff[rd_idx_ff] ? rd_data_ff : abcr_pkg::ENTRY_RESET;
   assign ign_done = (state_ff == ST_IDLE) && q_valid && q_item.ignore && out_free;
   assign commit   = (state_ff == ST_BUILD) && out_free;
   assign q_pop    = ign_done || commit;

   // scan evaluation: first id match wins; oldest age, lowest index on a tie
   assign match  = eval_ff && !hit_ff && (rd_entry.id == q_item.sender_id);
   assign better = eval_ff && ((rd_idx_ff == '0) || (rd_entry.age < best_age_ff));

   // reply build for the selected slot
   always_comb begin
      cur = '{id: q_item.sender_id, toggle: 1'b1, age: q_item.now_ms, reply: 40'd0,
              reply_length: abcr_pkg::LEN_NONE};
      if (hit_ff) begin
         cur = rd_entry;
      end
      isnew   = (q_item.abit != cur.toggle);
      hdr_ok  = abcr_pkg::header_of(cfg.response_code, q_item.abit);
      hdr_err = abcr_pkg::header_of(cfg.error_code, q_item.abit);
      built   = 1'b0;
      rep     = {32'd0, hdr_ok};
      rep_len = abcr_pkg::LEN_ACK;
      if (q_item.cmd_ping) begin
         built = q_item.ping_len_ok && isnew;
         if (!q_item.ack) begin
            rep     = {q_item.payload_bytes ^ abcr_pkg::PING_XOR, hdr_ok};
            rep_len = abcr_pkg::LEN_ECHO;
         end
      end else if (q_item.cmd_color) begin
         built = q_item.ack && isnew;
         if (!q_item.color_len_ok) begin
            rep     = {24'd0, cfg.bad_length_error, hdr_err};
            rep_len = abcr_pkg::LEN_ERR;
         end
      end else begin
         built   = q_item.ack && isnew;
         rep     = {24'd0, cfg.unknown_command_error, hdr_err};
         rep_len = abcr_pkg::LEN_ERR;
      end
      new_entry = cur;
      if (built) begin
         new_entry.reply        = rep;
         new_entry.reply_length = rep_len;
         new_entry.toggle       = !cur.toggle;
      end
      send = q_item.ack && (new_entry.reply_length != abcr_pkg::LEN_NONE);
   end

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      eval_in     = (state_ff == ST_SCAN);
      hit_in      = hit_ff | match;
      hit_idx_in  = match ? rd_idx_ff : hit_idx_ff;
      victim_in   = better ? rd_idx_ff : victim_ff;
      best_age_in = better ? rd_entry.age : best_age_ff;
      valid_in    = valid_ff;
      if (commit) begin
         valid_in[slot] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            hit_in      = 1'b0;
            if (q_valid && !q_item.ignore) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FETCH;
         ST_FETCH: state_in = ST_BUILD;
         ST_BUILD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      send_in      = send_ff;
      dest_id_in   = dest_id_ff;
      dest_port_in = dest_port_ff;
      rlen_in      = rlen_ff;
      rbytes_in    = rbytes_ff;
      if (ign_done || commit) begin
         rsp_valid_in = 1'b1;
         send_in      = commit && send;
         dest_id_in   = '0;
         dest_port_in = '0;
         rlen_in      = abcr_pkg::LEN_NONE;
         rbytes_in    = '0;
         if (commit && send) begin
            dest_id_in   = q_item.sender_id;
            dest_port_in = q_item.sender_port;
            rlen_in      = new_entry.reply_length;
            rbytes_in    = new_entry.reply;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         eval_ff      <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         eval_ff      <= eval_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff  <= scan_cnt_in;
      hit_idx_ff   <= hit_idx_in;
      victim_ff    <= victim_in;
      best_age_ff  <= best_age_in;
      send_ff      <= send_in;
      dest_id_ff   <= dest_id_in;
      dest_port_ff <= dest_port_in;
      rlen_ff      <= rlen_in;
      rbytes_ff    <= rbytes_in;
   end

   // connection table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (commit) begin
         peer_mem[slot] <= new_entry;
      end
      rd_data_ff <= peer_mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.send_reply   = send_ff;
   assign rsp_chan.dest_id      = dest_id_ff;
   assign rsp_chan.dest_port    = dest_port_ff;
   assign rsp_chan.reply_length = rlen_ff;
   assign rsp_chan.reply_bytes  = rbytes_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_commit_marks_valid: assert property (@(posedge clock) disable iff (reset)
      commit |=> (valid_ff != '0))
      else $error("table entry not marked valid after commit");

   a_build_after_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD) |-> ($past(state_ff) == ST_FETCH || $past(state_ff) == ST_BUILD))
      else $error("build entered without table fetch");

   a_silent_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !send_ff) |->
         (dest_id_ff == '0 && dest_port_ff == '0 && rlen_ff == '0 && rbytes_ff == '0))
      else $error("silent result carries non-zero fields");

   a_send_has_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && send_ff) |-> (rlen_ff != abcr_pkg::LEN_NONE))
      else $error("reply sent with zero length");

endmodule

>>> hw/rtl/alt_bit_command_responder_top.sv
// Top level of the alternating-bit command responder.
//
// req_chan carries one received datagram summary per transfer (valid/ready).
// rsp_chan returns exactly one result per request, in request order; a result
// with send_reply low has all other fields zero.
// csr_* is an APB-style register port; registers sit at byte address 4*i and
// must be written only while the block is idle, which the block does not enforce.
// Requests pass a classifier into a two-entry queue. The queue also holds the
// request the back end is working on, so one more request is taken while the
// back end is busy or the receiver stalls.
// Packets that are ignored retire at one per cycle while rsp_chan.ready stays high.
// A valid packet is handled in the back end as follows: the connection
// table is scanned one slot per cycle through its single read port, then the
// chosen slot is read back, updated and the result registered.
// While rsp_chan.ready is low the result register holds and the back end
// waits; the queue then fills and req_chan.ready drops.
// Synchronous reset empties the queue, drops any pending result, returns the
// registers to their defaults and marks every table slot empty.
module alt_bit_command_responder_top #(
   parameter int unsigned PEER_SLOTS   = abcr_pkg::PEER_SLOTS_DEF,
   parameter int unsigned MAX_DATAGRAM = abcr_pkg::MAX_DATAGRAM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   abcr_req_if.sink                          req_chan,
   abcr_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [abcr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [abcr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [abcr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   abcr_pkg::cfg_type   cfg;
   abcr_pkg::item_type  push_item, q_item;
   logic                push, full, q_valid, q_pop;

   abcr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   abcr_front #(
      .MAX_DATAGRAM (MAX_DATAGRAM)
   ) u_front (
      .req_chan    (req_chan),
      .cfg         (cfg),
      .q_full      (full),
      .q_push      (push),
      .q_push_item (push_item)
   );

   abcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .pop       (q_pop)
   );

   abcr_back #(
      .PEER_SLOTS (PEER_SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
